// ===== src/cbm_pkg.sv =====
// Package for the cartridge bank mapper: operation codes, decode constants and bank helpers.
package cbm_pkg;

    // Operation codes carried on the input tuser
    typedef enum logic [2:0] {
        OP_WRITE_HIGH = 3'd0,
        OP_WRITE_LOW  = 3'd1,
        OP_READ_LOW   = 3'd2,
        OP_LINE_TICK  = 3'd3,
        OP_PRG_XLATE  = 3'd4,
        OP_CHR_XLATE  = 3'd5
    } op_t;

    // Configuration register indexes
    localparam logic CFG_PRG_BANKS = 1'b0;
    localparam logic CFG_CHR_BANKS = 1'b1;

    localparam int PRG_SLOT_W = 9;
    localparam int CHR_SLOT_W = 11;

    // Bank count limits; counts are powers of two, so the wrap is a mask
    localparam logic [9:0]  MAX_PRG_BANKS = 10'd512;
    localparam logic [11:0] MAX_CHR_BANKS = 12'd2048;
    localparam logic [11:0] CHR_MODE_LIMIT = 12'd256;

    // Reset values of the configuration registers
    localparam logic [9:0]  PRG_BANKS_RST = 10'd32;
    localparam logic [11:0] CHR_BANKS_RST = 12'd256;
    localparam logic [7:0]  CHR_MODE_RST  = 8'h30;

    // Write decode, high area
    localparam logic [15:0] ADDR_OUTER_0  = 16'h8000;
    localparam logic [15:0] ADDR_OUTER_1  = 16'hB000;
    localparam logic [15:0] ADDR_OUTER_2  = 16'hB0FF;
    localparam logic [15:0] ADDR_OUTER_3  = 16'hB1FF;
    localparam logic [15:0] ADDR_CHR_MODE = 16'h8100;
    localparam logic [15:0] ADDR_CNT_LO   = 16'h8200;
    localparam logic [15:0] ADDR_CNT_HI   = 16'h8201;
    localparam logic [15:0] ADDR_PRG_BASE = 16'h8300;
    localparam logic [15:0] ADDR_CHR_BASE = 16'h8310;
    localparam logic [15:0] ADDR_PRG_PAIR = 16'h8318;

    // Low area
    localparam logic [15:0] ADDR_LATCH_LO = 16'h5101;
    localparam logic [15:0] ADDR_LATCH_HI = 16'h5103;
    localparam logic [15:0] LATCH_MATCH   = 16'h5100;

    // Windows for translation
    localparam logic [15:0] PRG_WINDOW    = 16'h8000;
    localparam logic [15:0] CHR_WINDOW    = 16'h2000;

    localparam logic [7:0]  OUTER_MASK    = 8'h30;
    localparam logic [7:0]  UPPER_LOW     = 8'h0F;
    localparam logic [1:0]  MIRROR_MASK   = 2'h3;
    localparam logic [15:0] LINE_STEP     = 16'd114;

    // 8K program bank wrap
    function automatic logic [PRG_SLOT_W-1:0] prg_wrap(input logic [9:0] bank,
                                                       input logic [9:0] mask);
        logic [9:0] m;
        m = bank & mask;
        return m[PRG_SLOT_W-1:0];
    endfunction

    // 1K pattern bank wrap
    function automatic logic [CHR_SLOT_W-1:0] chr_wrap(input logic [10:0] bank,
                                                       input logic [11:0] mask);
        logic [11:0] m;
        m = {1'b0, bank} & mask;
        return m[CHR_SLOT_W-1:0];
    endfunction

    // First slot of the 2K pair loaded by a pattern write in 2K mode
    function automatic logic [2:0] chr_pair(input logic [2:0] idx);
        logic [2:0] p;
        unique case (idx)
            3'd0:    p = 3'd0;
            3'd1:    p = 3'd2;
            3'd2:    p = 3'd4;
            3'd3:    p = 3'd6;
            3'd4:    p = 3'd4;
            3'd5:    p = 3'd6;
            3'd6:    p = 3'd4;
            default: p = 3'd6;
        endcase
        return p;
    endfunction

endpackage

// ===== src/cartridge_bank_mapper_with_line_irq.sv =====
// Cartridge bank mapper with scanline interrupt counter, top level.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------------
//  s_       | in        | s_tvalid/s_tready  | tuser: operation; tdata: address, data
//  m_       | out       | m_tvalid/m_tready  | tdata: read, irq, prg/chr address, mirror
//  cfg_     | in        | cfg_wr_en          | cfg_addr: register, cfg_wdata: value
//
// One transaction in, one transaction out. Each passes through an input
// register, then the decode/lookup/update logic into the result register.
// A new transaction is taken every cycle while the output is drained; the
// bank slots and counter update in the cycle the transaction moves to the
// output register, so the next one sees them at once.
// Reset is synchronous, active low; it restores the default bank layout.
// A stall on m_tready holds the result and backs up into s_tready.
module cartridge_bank_mapper_with_line_irq
    import cbm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [15:0] address, [23:16] write_data
    input  logic [2:0]  s_tuser,    // [2:0] operation

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // [7:0] read_data, [8] irq_request,
                                    // [30:9] prg_address, [51:31] chr_address,
                                    // [53:52] mirroring, [55:54] zero

    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [11:0] cfg_wdata
);

    // Configuration
    logic [9:0]  prg_banks_reg;
    logic [11:0] chr_banks_reg;

    // Input stage
    logic        in_valid_reg;
    op_t         in_op_reg;
    logic [15:0] in_addr_reg;
    logic [7:0]  in_data_reg;

    // Output stage
    logic        out_valid_reg;
    logic [55:0] out_tdata_reg;
    logic [55:0] out_tdata_next;

    // Mapper state
    logic [PRG_SLOT_W-1:0] prg_slot_reg  [4];
    logic [PRG_SLOT_W-1:0] prg_slot_next [4];
    logic [CHR_SLOT_W-1:0] chr_slot_reg  [8];
    logic [CHR_SLOT_W-1:0] chr_slot_next [8];
    logic [7:0]  outer_mode_reg, outer_mode_next;
    logic [7:0]  chr_mode_reg,   chr_mode_next;
    logic [7:0]  latch_reg,      latch_next;
    logic [9:0]  chr_high_reg,   chr_high_next;
    logic [15:0] line_count_reg, line_count_next;
    logic        count_en_reg,   count_en_next;
    logic [1:0]  mirror_reg,     mirror_next;

    logic        out_ready;
    logic        fire;

    // Bank wrap masks
    logic [9:0]  prg_n;
    logic [9:0]  prg_mask;
    logic [11:0] chr_n;
    logic [11:0] chr_mask;

    // Result fields
    logic [7:0]  rd;
    logic        irq;
    logic [21:0] pa;
    logic [20:0] ca;

    // Decode helpers
    logic [9:0]  b16;
    logic [9:0]  chr_v;
    logic [2:0]  cidx;
    logic [2:0]  cpair;
    logic [7:0]  pair_bank;

    assign out_ready = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_tdata_reg;

    // Clamp the bank counts; the mask is count-1 for power-of-two sizes
    always_comb begin
        if (prg_banks_reg > MAX_PRG_BANKS) begin
            prg_n = MAX_PRG_BANKS;
        end else if (prg_banks_reg == 10'd0) begin
            prg_n = 10'd1;
        end else begin
            prg_n = prg_banks_reg;
        end
        prg_mask = prg_n - 10'd1;
        chr_n    = (chr_banks_reg > MAX_CHR_BANKS) ? MAX_CHR_BANKS : chr_banks_reg;
        chr_mask = chr_n - 12'd1;
    end

    always_comb begin
        prg_slot_next   = prg_slot_reg;
        chr_slot_next   = chr_slot_reg;
        outer_mode_next = outer_mode_reg;
        chr_mode_next   = chr_mode_reg;
        latch_next      = latch_reg;
        chr_high_next   = chr_high_reg;
        line_count_next = line_count_reg;
        count_en_next   = count_en_reg;
        mirror_next     = mirror_reg;
        rd  = '0;
        irq = 1'b0;
        pa  = '0;
        ca  = '0;

        // 16K pair bank for the outer-mode writes: data, then the upper pair
        b16       = {2'b00, in_data_reg};
        pair_bank = (in_data_reg & OUTER_MASK) | UPPER_LOW;
        chr_v     = chr_high_reg ^ {2'b00, in_data_reg};
        cidx      = in_addr_reg[2:0];
        cpair     = chr_pair(cidx);

        unique case (in_op_reg)
            OP_WRITE_HIGH: begin
                priority if (in_addr_reg == ADDR_OUTER_0 || in_addr_reg == ADDR_OUTER_1 ||
                             in_addr_reg == ADDR_OUTER_2 || in_addr_reg == ADDR_OUTER_3) begin
                    outer_mode_next  = in_data_reg;
                    chr_high_next    = {in_data_reg[5:4], 8'h00};
                    prg_slot_next[0] = prg_wrap({b16[8:0], 1'b0}, prg_mask);
                    prg_slot_next[1] = prg_wrap({b16[8:0], 1'b1}, prg_mask);
                    prg_slot_next[2] = prg_wrap({1'b0, pair_bank, 1'b0}, prg_mask);
                    prg_slot_next[3] = prg_wrap({1'b0, pair_bank, 1'b1}, prg_mask);
                end else if (in_addr_reg == ADDR_CHR_MODE) begin
                    if (chr_banks_reg <= CHR_MODE_LIMIT) begin
                        chr_mode_next = in_data_reg;
                    end
                    mirror_next = in_data_reg[1:0] & MIRROR_MASK;
                end else if (in_addr_reg == ADDR_CNT_LO) begin
                    line_count_next = {line_count_reg[15:8], in_data_reg};
                end else if (in_addr_reg == ADDR_CNT_HI) begin
                    line_count_next = {in_data_reg, line_count_reg[7:0]};
                    count_en_next   = (in_data_reg != 8'd0);
                end else if (in_addr_reg[15:2] == ADDR_PRG_BASE[15:2] &&
                             in_addr_reg[1:0] != 2'd3) begin
                    prg_slot_next[in_addr_reg[1:0]] = prg_wrap(b16, prg_mask);
                end else if (in_addr_reg[15:3] == ADDR_CHR_BASE[15:3]) begin
                    // Pattern RAM (count zero) keeps its fixed layout
                    if (chr_n != 12'd0) begin
                        if (chr_mode_reg[5:4] == 2'b11) begin
                            chr_slot_next[cidx] = chr_wrap({1'b0, chr_v}, chr_mask);
                        end else if (chr_mode_reg[5:4] != 2'b00) begin
                            chr_slot_next[cpair] = chr_wrap({chr_v, 1'b0}, chr_mask);
                            chr_slot_next[{cpair[2:1], 1'b1}] =
                                chr_wrap({chr_v, 1'b1}, chr_mask);
                        end
                    end
                end else if (in_addr_reg == ADDR_PRG_PAIR) begin
                    prg_slot_next[0] = prg_wrap(
                        {1'b0, (outer_mode_reg & OUTER_MASK) | in_data_reg, 1'b0}, prg_mask);
                    prg_slot_next[1] = prg_wrap(
                        {1'b0, (outer_mode_reg & OUTER_MASK) | in_data_reg, 1'b1}, prg_mask);
                end else begin
                    // unmapped address: ignored
                end
            end
            OP_WRITE_LOW: begin
                if (in_addr_reg >= ADDR_LATCH_LO && in_addr_reg <= ADDR_LATCH_HI) begin
                    latch_next = in_data_reg;
                end
            end
            OP_READ_LOW: begin
                rd = ((in_addr_reg & LATCH_MATCH) == LATCH_MATCH) ? latch_reg
                                                                  : in_addr_reg[15:8];
            end
            OP_LINE_TICK: begin
                // Interrupt fires on every line once the count reaches one step
                if (count_en_reg) begin
                    if (line_count_reg <= LINE_STEP) begin
                        irq = 1'b1;
                    end else begin
                        line_count_next = line_count_reg - LINE_STEP;
                    end
                end
            end
            OP_PRG_XLATE: begin
                if (in_addr_reg >= PRG_WINDOW) begin
                    pa = {prg_slot_reg[in_addr_reg[14:13]], in_addr_reg[12:0]};
                end
            end
            OP_CHR_XLATE: begin
                if (in_addr_reg < CHR_WINDOW) begin
                    ca = {chr_slot_reg[in_addr_reg[12:10]], in_addr_reg[9:0]};
                end
            end
            default: begin
                // undefined operation codes change nothing
            end
        endcase

        out_tdata_next = {2'b00, mirror_next, ca, pa, irq, rd};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_banks_reg   <= PRG_BANKS_RST;
            chr_banks_reg   <= CHR_BANKS_RST;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            // Default layout for a 32-bank program ROM
            prg_slot_reg[0] <= 9'd0;
            prg_slot_reg[1] <= 9'd1;
            prg_slot_reg[2] <= 9'd30;
            prg_slot_reg[3] <= 9'd31;
            for (int i = 0; i < 8; i++) begin
                chr_slot_reg[i] <= CHR_SLOT_W'(i);
            end
            outer_mode_reg  <= 8'd0;
            chr_mode_reg    <= CHR_MODE_RST;
            latch_reg       <= 8'd0;
            chr_high_reg    <= 10'd0;
            line_count_reg  <= 16'd0;
            count_en_reg    <= 1'b0;
            mirror_reg      <= 2'd0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_PRG_BANKS: prg_banks_reg <= cfg_wdata[9:0];
                    default:       chr_banks_reg <= cfg_wdata;
                endcase
            end

            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end

            if (fire) begin
                prg_slot_reg   <= prg_slot_next;
                chr_slot_reg   <= chr_slot_next;
                outer_mode_reg <= outer_mode_next;
                chr_mode_reg   <= chr_mode_next;
                latch_reg      <= latch_next;
                chr_high_reg   <= chr_high_next;
                line_count_reg <= line_count_next;
                count_en_reg   <= count_en_next;
                mirror_reg     <= mirror_next;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= op_t'(s_tuser);
            in_addr_reg <= s_tdata[15:0];
            in_data_reg <= s_tdata[23:16];
        end
        if (fire) begin
            out_tdata_reg <= out_tdata_next;
        end
    end

endmodule
